[hw/rtl/xtc_pkg.sv]
// shared widths, constants and register codes for the xyz to cmyk pixel unit
`timescale 1ns / 1ps
package xtc_pkg;

    localparam int COMP_W     = 24;
    localparam int WHITE_W    = 23;
    localparam int NORM_W     = 18;
    localparam int CHAN_W     = 19;
    localparam int INK_W      = 8;
    localparam int DIFF_W     = 18;
    localparam int INK_NUM_W  = DIFF_W + INK_W;
    localparam int IK_W       = 17;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam int STEPS_PER_STAGE = 2;
    localparam int NORM_STAGES     = NORM_W / STEPS_PER_STAGE;
    localparam int INK_STAGES      = INK_W / STEPS_PER_STAGE;

    // latency: norm divider, four arithmetic stages, ink divider, output register
    localparam int NORM_LAT  = NORM_STAGES + 3;
    localparam int INK_LAT   = INK_STAGES + 2;
    localparam int PIPE_LAT  = NORM_LAT + 4 + INK_LAT + 1;
    localparam int SIDE_LAT  = INK_LAT + 1;

    localparam logic [WHITE_W-1:0] WHITE_X_RST = 23'd389313;
    localparam logic [WHITE_W-1:0] WHITE_Y_RST = 23'd409600;
    localparam logic [WHITE_W-1:0] WHITE_Z_RST = 23'd445985;

    localparam logic signed [CHAN_W-1:0] ONE_Q16  = 19'sd65536;
    localparam logic [NORM_W-1:0]        NORM_MAX = 18'h1FFFF;
    localparam logic [NORM_W-1:0]        NORM_MIN = 18'h20000;
    localparam logic [INK_W-1:0]         INK_FULL = 8'd255;

    typedef enum logic [1:0] {
        REG_WHITE_X = 2'd0,
        REG_WHITE_Y = 2'd1,
        REG_WHITE_Z = 2'd2
    } reg_idx_t;

endpackage

[hw/rtl/xtc_norm_div.sv]
// pipelined signed division of one xyz component by its white point, saturated to q2.16
`timescale 1ns / 1ps
module xtc_norm_div (
    input  logic                              clk,
    input  logic signed [xtc_pkg::COMP_W-1:0] comp,
    input  logic [xtc_pkg::WHITE_W-1:0]       white,
    output logic signed [xtc_pkg::NORM_W-1:0] norm
);
    import xtc_pkg::*;

    logic [WHITE_W-1:0] w_eff;
    logic [COMP_W-1:0]  comp_u;
    logic [COMP_W-1:0]  mag_reg;
    logic               sign_reg;

    logic [WHITE_W-1:0] rem_reg  [0:NORM_STAGES];
    logic [NORM_W-1:0]  quo_reg  [0:NORM_STAGES];
    logic [NORM_W-1:0]  tail_reg [0:NORM_STAGES];
    logic               neg_reg  [0:NORM_STAGES];
    logic               ovf_reg  [0:NORM_STAGES];

    logic [WHITE_W-1:0] rem_next  [1:NORM_STAGES];
    logic [NORM_W-1:0]  quo_next  [1:NORM_STAGES];
    logic [NORM_W-1:0]  tail_next [1:NORM_STAGES];

    logic [WHITE_W:0]   head;
    logic               ovf0;
    logic [NORM_W-1:0]  mag_out;
    logic [NORM_W-1:0]  norm_next;
    logic [NORM_W-1:0]  norm_reg;

    // a zero white point acts as one lsb
    assign w_eff  = (white == '0) ? WHITE_W'(1) : white;
    assign comp_u = comp;

    always_ff @(posedge clk)
    begin
        mag_reg  <= comp_u[COMP_W-1] ? (~comp_u + COMP_W'(1)) : comp_u;
        sign_reg <= comp_u[COMP_W-1];
    end

    // quotient above 18 bits only ever saturates
    assign head = {2'b00, mag_reg[COMP_W-1:2]};
    assign ovf0 = (head >= {1'b0, w_eff});

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= ovf0 ? '0 : head[WHITE_W-1:0];
        quo_reg[0]  <= '0;
        tail_reg[0] <= {mag_reg[1:0], 16'h0000};
        neg_reg[0]  <= sign_reg;
        ovf_reg[0]  <= ovf0;
    end

    for (genvar j = 1; j <= NORM_STAGES; j++)
    begin : g_step
        always_comb
        begin
            logic [WHITE_W-1:0] r;
            logic [NORM_W-1:0]  q;
            logic [NORM_W-1:0]  d;
            logic [WHITE_W:0]   t;
            r = rem_reg[j-1];
            q = quo_reg[j-1];
            d = tail_reg[j-1];
            for (int s = 0; s < STEPS_PER_STAGE; s++)
            begin
                t = {r, d[NORM_W-1]};
                d = {d[NORM_W-2:0], 1'b0};
                if (t >= {1'b0, w_eff})
                begin
                    t = t - {1'b0, w_eff};
                    q = {q[NORM_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[NORM_W-2:0], 1'b0};
                end
                r = t[WHITE_W-1:0];
            end
            rem_next[j]  = r;
            quo_next[j]  = q;
            tail_next[j] = d;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= rem_next[j];
            quo_reg[j]  <= quo_next[j];
            tail_reg[j] <= tail_next[j];
            neg_reg[j]  <= neg_reg[j-1];
            ovf_reg[j]  <= ovf_reg[j-1];
        end
    end

    // saturate to -2.0 .. 2.0 - lsb and apply sign
    always_comb
    begin
        mag_out = ovf_reg[NORM_STAGES] ? '1 : quo_reg[NORM_STAGES];
        if (neg_reg[NORM_STAGES])
            norm_next = (mag_out > NORM_MIN) ? NORM_MIN : (~mag_out + NORM_W'(1));
        else
            norm_next = (mag_out > NORM_MAX) ? NORM_MAX : mag_out;
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
    end

    assign norm = norm_reg;

endmodule

[hw/rtl/xtc_ink_div.sv]
// pipelined unsigned division for one chromatic ink, clipped to 255
`timescale 1ns / 1ps
module xtc_ink_div (
    input  logic                           clk,
    input  logic [xtc_pkg::INK_NUM_W-1:0]  num,
    input  logic [xtc_pkg::IK_W-1:0]       den,
    output logic [xtc_pkg::INK_W-1:0]      ink
);
    import xtc_pkg::*;

    logic [IK_W-1:0]  rem_reg  [0:INK_STAGES];
    logic [INK_W-1:0] quo_reg  [0:INK_STAGES];
    logic [INK_W-1:0] tail_reg [0:INK_STAGES];
    logic [IK_W-1:0]  den_reg  [0:INK_STAGES];
    logic             ovf_reg  [0:INK_STAGES];

    logic [IK_W-1:0]  rem_next  [1:INK_STAGES];
    logic [INK_W-1:0] quo_next  [1:INK_STAGES];
    logic [INK_W-1:0] tail_next [1:INK_STAGES];

    logic [DIFF_W-1:0] head;
    logic              ovf0;
    logic [INK_W-1:0]  ink_reg;

    assign head = num[INK_NUM_W-1:INK_W];
    assign ovf0 = (head >= {1'b0, den});

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= ovf0 ? '0 : head[IK_W-1:0];
        quo_reg[0]  <= '0;
        tail_reg[0] <= num[INK_W-1:0];
        den_reg[0]  <= den;
        ovf_reg[0]  <= ovf0;
    end

    for (genvar j = 1; j <= INK_STAGES; j++)
    begin : g_step
        always_comb
        begin
            logic [IK_W-1:0]  r;
            logic [INK_W-1:0] q;
            logic [INK_W-1:0] d;
            logic [IK_W:0]    t;
            r = rem_reg[j-1];
            q = quo_reg[j-1];
            d = tail_reg[j-1];
            for (int s = 0; s < STEPS_PER_STAGE; s++)
            begin
                t = {r, d[INK_W-1]};
                d = {d[INK_W-2:0], 1'b0};
                if (t >= {1'b0, den_reg[j-1]})
                begin
                    t = t - {1'b0, den_reg[j-1]};
                    q = {q[INK_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[INK_W-2:0], 1'b0};
                end
                r = t[IK_W-1:0];
            end
            rem_next[j]  = r;
            quo_next[j]  = q;
            tail_next[j] = d;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= rem_next[j];
            quo_reg[j]  <= quo_next[j];
            tail_reg[j] <= tail_next[j];
            den_reg[j]  <= den_reg[j-1];
            ovf_reg[j]  <= ovf_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ink_reg <= ovf_reg[INK_STAGES] ? INK_FULL : quo_reg[INK_STAGES];
    end

    assign ink = ink_reg;

endmodule

[hw/rtl/xyz_to_cmyk_pixel_unit.sv]
// top level of the xyz to cmyk pixel unit: register port, pipeline control and ink math
`timescale 1ns / 1ps
// xyz to cmyk pixel unit. one signed q12.12 xyz pixel is taken on every clock
// where start is high; busy never rises, so a pixel may follow in the very next
// cycle. the result leaves 23 cycles after its transfer, on the cycle where
// result_valid is high, for that one cycle only: the receiver cannot stall and
// must take it then. latency is set by the two restoring dividers (two quotient
// bits per stage): 12 stages for the white point normalize, 4 for the
// c/m/y/k and ik math, 6 for the ink divide and one output register. the white
// point registers sit at byte addresses 0, 4 and 8 of the apb port; write them
// only while no pixel is in flight. a white point of zero acts as one lsb.
module xyz_to_cmyk_pixel_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [xtc_pkg::ADDR_W-1:0]         paddr,
    input  logic [xtc_pkg::DATA_W-1:0]         pwdata,
    output logic [xtc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // pixel in
    input  logic                               start,
    output logic                               busy,
    input  logic signed [xtc_pkg::COMP_W-1:0]  x_value,
    input  logic signed [xtc_pkg::COMP_W-1:0]  y_value,
    input  logic signed [xtc_pkg::COMP_W-1:0]  z_value,
    input  logic                               line_end,
    // pixel out
    output logic                               result_valid,
    output logic [xtc_pkg::INK_W-1:0]          cyan,
    output logic [xtc_pkg::INK_W-1:0]          magenta,
    output logic [xtc_pkg::INK_W-1:0]          yellow,
    output logic [xtc_pkg::INK_W-1:0]          black,
    output logic                               end_of_line
);
    import xtc_pkg::*;

    // white point registers
    logic [WHITE_W-1:0] white_x_reg;
    logic [WHITE_W-1:0] white_y_reg;
    logic [WHITE_W-1:0] white_z_reg;
    logic               cfg_write;
    reg_idx_t           cfg_idx;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_x_reg <= WHITE_X_RST;
            white_y_reg <= WHITE_Y_RST;
            white_z_reg <= WHITE_Z_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_WHITE_X: white_x_reg <= pwdata[WHITE_W-1:0];
                REG_WHITE_Y: white_y_reg <= pwdata[WHITE_W-1:0];
                REG_WHITE_Z: white_z_reg <= pwdata[WHITE_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WHITE_X: prdata = DATA_W'(white_x_reg);
            REG_WHITE_Y: prdata = DATA_W'(white_y_reg);
            REG_WHITE_Z: prdata = DATA_W'(white_z_reg);
            default:     prdata = '0;
        endcase
    end

    // valid and line end travel alongside the data for the full depth
    logic vld_reg [0:PIPE_LAT-1];
    logic eol_reg [0:PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start & ~busy;
            for (int i = 1; i < PIPE_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        eol_reg[0] <= line_end;
        for (int i = 1; i < PIPE_LAT; i++)
            eol_reg[i] <= eol_reg[i-1];
    end

    // normalize each component against its white point
    logic signed [NORM_W-1:0] r_norm;
    logic signed [NORM_W-1:0] g_norm;
    logic signed [NORM_W-1:0] b_norm;

    xtc_norm_div u_norm_x (.clk(clk), .comp(x_value), .white(white_x_reg), .norm(r_norm));
    xtc_norm_div u_norm_y (.clk(clk), .comp(y_value), .white(white_y_reg), .norm(g_norm));
    xtc_norm_div u_norm_z (.clk(clk), .comp(z_value), .white(white_z_reg), .norm(b_norm));

    // c, m, y = 1 - normalized value
    logic signed [CHAN_W-1:0] c_reg, m_reg, y_reg;

    always_ff @(posedge clk)
    begin
        c_reg <= ONE_Q16 - CHAN_W'(r_norm);
        m_reg <= ONE_Q16 - CHAN_W'(g_norm);
        y_reg <= ONE_Q16 - CHAN_W'(b_norm);
    end

    // k = min(c, m, y)
    logic signed [CHAN_W-1:0] c2_reg, m2_reg, y2_reg, k_reg;
    logic signed [CHAN_W-1:0] cm_min;
    logic signed [CHAN_W-1:0] k_next;

    always_comb
    begin
        cm_min = (m_reg < c_reg) ? m_reg : c_reg;
        k_next = (y_reg < cm_min) ? y_reg : cm_min;
    end

    always_ff @(posedge clk)
    begin
        c2_reg <= c_reg;
        m2_reg <= m_reg;
        y2_reg <= y_reg;
        k_reg  <= k_next;
    end

    // ik, dark test, chroma differences and black ink
    logic signed [CHAN_W-1:0] ik_full;
    logic signed [CHAN_W-1:0] dc_full, dm_full, dy_full;
    logic [INK_NUM_W-1:0]     kprod;
    logic [INK_NUM_W-INK_W-DIFF_W+9:0] kscaled;
    logic [INK_W-1:0]         blk_next;

    logic [DIFF_W-1:0] dc_reg, dm_reg, dy_reg;
    logic [IK_W-1:0]   ik_reg;
    logic              dark_reg;
    logic [INK_W-1:0]  blk_reg;

    always_comb
    begin
        ik_full = ONE_Q16 - k_reg;
        dc_full = c2_reg - k_reg;
        dm_full = m2_reg - k_reg;
        dy_full = y2_reg - k_reg;
        kprod   = INK_NUM_W'(k_reg[DIFF_W-1:0]) * INK_NUM_W'(INK_FULL);
        kscaled = kprod[INK_NUM_W-1:16];
        if (k_reg > 0)
            blk_next = (kscaled > 10'(INK_FULL)) ? INK_FULL : kscaled[INK_W-1:0];
        else
            blk_next = '0;
    end

    always_ff @(posedge clk)
    begin
        dc_reg   <= dc_full[DIFF_W-1:0];
        dm_reg   <= dm_full[DIFF_W-1:0];
        dy_reg   <= dy_full[DIFF_W-1:0];
        ik_reg   <= ik_full[IK_W-1:0];
        dark_reg <= (ik_full <= 0);
        blk_reg  <= blk_next;
    end

    // scale differences by 255; dark pixels divide by one to keep the path tame
    logic [INK_NUM_W-1:0] nc_reg, nm_reg, ny_reg;
    logic [IK_W-1:0]      den_reg;
    logic                 side_dark_reg [0:SIDE_LAT-1];
    logic [INK_W-1:0]     side_blk_reg  [0:SIDE_LAT-1];

    always_ff @(posedge clk)
    begin
        nc_reg  <= INK_NUM_W'(dc_reg) * INK_NUM_W'(INK_FULL);
        nm_reg  <= INK_NUM_W'(dm_reg) * INK_NUM_W'(INK_FULL);
        ny_reg  <= INK_NUM_W'(dy_reg) * INK_NUM_W'(INK_FULL);
        den_reg <= dark_reg ? IK_W'(1) : ik_reg;
        side_dark_reg[0] <= dark_reg;
        side_blk_reg[0]  <= blk_reg;
        for (int i = 1; i < SIDE_LAT; i++)
        begin
            side_dark_reg[i] <= side_dark_reg[i-1];
            side_blk_reg[i]  <= side_blk_reg[i-1];
        end
    end

    logic [INK_W-1:0] ink_c, ink_m, ink_y;

    xtc_ink_div u_ink_c (.clk(clk), .num(nc_reg), .den(den_reg), .ink(ink_c));
    xtc_ink_div u_ink_m (.clk(clk), .num(nm_reg), .den(den_reg), .ink(ink_m));
    xtc_ink_div u_ink_y (.clk(clk), .num(ny_reg), .den(den_reg), .ink(ink_y));

    // output register; dark pixels force full ink on all four channels
    logic [INK_W-1:0] cyan_reg, magenta_reg, yellow_reg, black_reg;
    logic             dark_out;

    assign dark_out = side_dark_reg[SIDE_LAT-1];

    always_ff @(posedge clk)
    begin
        cyan_reg    <= dark_out ? INK_FULL : ink_c;
        magenta_reg <= dark_out ? INK_FULL : ink_m;
        yellow_reg  <= dark_out ? INK_FULL : ink_y;
        black_reg   <= dark_out ? INK_FULL : side_blk_reg[SIDE_LAT-1];
    end

    assign result_valid = vld_reg[PIPE_LAT-1];
    assign end_of_line  = eol_reg[PIPE_LAT-1];
    assign cyan         = cyan_reg;
    assign magenta      = magenta_reg;
    assign yellow       = yellow_reg;
    assign black        = black_reg;

endmodule
